// ===== hw/rtl/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg: shared definitions for the text console engine
// Field widths, character codes, event and operation codes, and the
// operation record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tccs_pkg;

	// Default screen geometry and queue depth.
	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 25;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// Fixed field widths of the cursor coordinates.
	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	// Character and color constants.
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

	// Input modes.
	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_SET   = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// Event kinds reported on the result channel.
	typedef enum logic [2:0] {
		EV_CHAR   = 3'd0,
		EV_LINE   = 3'd1,
		EV_SCROLL = 3'd2,
		EV_REDRAW = 3'd3,
		EV_DATA   = 3'd4
	} ev_kind_t;

	// Work the back end carries out for one result.
	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_EMIT   = 3'd1,
		OP_READ   = 3'd2,
		OP_SCROLL = 3'd3,
		OP_CLEAR  = 3'd4
	} op_kind_t;

	// One queued operation; it produces exactly one result.
	typedef struct packed {
		op_kind_t         op;
		ev_kind_t         ev;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [7:0]       ch;
		logic             last;
	} op_t;

	// One result item.
	typedef struct packed {
		ev_kind_t         kind;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [15:0]      cell_value;
		logic             last;
	} ev_t;

endpackage

// ===== hw/rtl/tccs_front.sv =====
// ----------------------------------------------------------------------------
// tccs_front: command front end
// Accepts input items, keeps the cursor, and breaks each item into one to
// three operations, handed to the queue one per cycle while it has room.
// ----------------------------------------------------------------------------
module tccs_front #(
	parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        mode,
	input  logic [7:0]        char_code,
	input  logic [7:0]        target_col,
	input  logic [7:0]        target_row,
	input  logic              init_done,
	output logic              q_valid,
	input  logic              q_ready,
	output tccs_pkg::op_t     q_op
);

	localparam logic [tccs_pkg::COL_W-1:0] COL_MAX = tccs_pkg::COL_W'(SCREEN_WIDTH - 1);
	localparam logic [tccs_pkg::ROW_W-1:0] ROW_MAX = tccs_pkg::ROW_W'(SCREEN_HEIGHT - 1);

	logic [tccs_pkg::COL_W-1:0] cur_col_q;
	logic [tccs_pkg::ROW_W-1:0] cur_row_q;
	tccs_pkg::op_t              pend_q [3];
	logic [1:0]                 pend_cnt_q;

	tccs_pkg::op_t              ops [3];
	logic [1:0]                 n_ops;
	logic [tccs_pkg::COL_W-1:0] new_col;
	logic [tccs_pkg::ROW_W-1:0] new_row;
	logic [tccs_pkg::COL_W-1:0] col_clamp;
	logic [tccs_pkg::ROW_W-1:0] row_clamp;
	logic                       at_right;
	logic                       at_bottom;
	logic                       accept;

	function automatic tccs_pkg::op_t mk_op(
		input tccs_pkg::op_kind_t         op,
		input tccs_pkg::ev_kind_t         ev,
		input logic [tccs_pkg::COL_W-1:0] col,
		input logic [tccs_pkg::ROW_W-1:0] row,
		input logic [7:0]                 ch,
		input logic                       last
	);
		tccs_pkg::op_t r;
		r.op   = op;
		r.ev   = ev;
		r.col  = col;
		r.row  = row;
		r.ch   = ch;
		r.last = last;
		return r;
	endfunction

	// A new item is taken only once every operation of the previous one is queued.
	assign in_ready = (pend_cnt_q == 2'd0) && init_done;
	assign accept   = in_valid && in_ready;
	assign q_valid  = (pend_cnt_q != 2'd0);
	assign q_op     = pend_q[0];

	// Clamp targets and detect the right edge and the bottom row.
	always_comb begin
		col_clamp = (target_col >= 8'(SCREEN_WIDTH)) ? COL_MAX : target_col[tccs_pkg::COL_W-1:0];
		row_clamp = (target_row >= 8'(SCREEN_HEIGHT)) ? ROW_MAX : target_row[tccs_pkg::ROW_W-1:0];
		at_right  = (cur_col_q == COL_MAX);
		at_bottom = (cur_row_q == ROW_MAX);
	end

	// Classify the item into its list of operations and the next cursor.
	always_comb begin
		new_col = cur_col_q;
		new_row = cur_row_q;
		n_ops   = 2'd1;
		ops[0]  = '0;
		ops[1]  = '0;
		ops[2]  = '0;
		case (tccs_pkg::mode_t'(mode))
			tccs_pkg::MODE_PUT: begin
				if (char_code == tccs_pkg::CHAR_NEWLINE) begin
					ops[0] = mk_op(tccs_pkg::OP_EMIT, tccs_pkg::EV_LINE, '0, cur_row_q, 8'h00,
						!at_bottom);
					ops[1] = mk_op(tccs_pkg::OP_SCROLL, tccs_pkg::EV_SCROLL, '0, ROW_MAX, 8'h00,
						1'b1);
					n_ops   = at_bottom ? 2'd2 : 2'd1;
					new_col = '0;
					new_row = at_bottom ? cur_row_q : cur_row_q + 1'b1;
				end else begin
					ops[0] = mk_op(tccs_pkg::OP_WRITE, tccs_pkg::EV_CHAR, cur_col_q, cur_row_q,
						char_code, !at_right);
					ops[1] = mk_op(tccs_pkg::OP_EMIT, tccs_pkg::EV_LINE, '0, cur_row_q, 8'h00,
						!at_bottom);
					ops[2] = mk_op(tccs_pkg::OP_SCROLL, tccs_pkg::EV_SCROLL, '0, ROW_MAX, 8'h00,
						1'b1);
					if (at_right) begin
						n_ops   = at_bottom ? 2'd3 : 2'd2;
						new_col = '0;
						new_row = at_bottom ? cur_row_q : cur_row_q + 1'b1;
					end else begin
						new_col = cur_col_q + 1'b1;
					end
				end
			end
			tccs_pkg::MODE_CLEAR: begin
				ops[0] = mk_op(tccs_pkg::OP_CLEAR, tccs_pkg::EV_REDRAW, cur_col_q, cur_row_q,
					8'h00, 1'b1);
			end
			tccs_pkg::MODE_SET: begin
				ops[0] = mk_op(tccs_pkg::OP_EMIT, tccs_pkg::EV_DATA, col_clamp, row_clamp,
					8'h00, 1'b1);
				new_col = col_clamp;
				new_row = row_clamp;
			end
			default: begin
				ops[0] = mk_op(tccs_pkg::OP_READ, tccs_pkg::EV_DATA, col_clamp, row_clamp,
					8'h00, 1'b1);
			end
		endcase
	end

	// Cursor and pending operation buffer; the buffer shifts as the queue takes entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			cur_col_q  <= new_col;
			cur_row_q  <= new_row;
			pend_cnt_q <= n_ops;
			pend_q[0]  <= ops[0];
			pend_q[1]  <= ops[1];
			pend_q[2]  <= ops[2];
		end else if (q_valid && q_ready) begin
			pend_cnt_q <= pend_cnt_q - 1'b1;
			pend_q[0]  <= pend_q[1];
			pend_q[1]  <= pend_q[2];
		end
	end

endmodule

// ===== hw/rtl/tccs_queue.sv =====
// ----------------------------------------------------------------------------
// tccs_queue: operation queue
// A small first-in first-out buffer of operations between the front end
// and the back end, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module tccs_queue #(
	parameter int DEPTH = tccs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tccs_pkg::op_t in_op,
	output logic          out_valid,
	input  logic          out_ready,
	output tccs_pkg::op_t out_op
);

	localparam int PTR_W = $clog2(DEPTH);

	tccs_pkg::op_t    buf_q [DEPTH];
	logic [PTR_W:0]   wr_ptr_q;
	logic [PTR_W:0]   rd_ptr_q;
	logic             full;
	logic             empty;

	// Pointers carry one extra wrap bit to tell full from empty.
	assign empty     = (wr_ptr_q == rd_ptr_q);
	assign full      = (wr_ptr_q[PTR_W] != rd_ptr_q[PTR_W]) &&
	                   (wr_ptr_q[PTR_W-1:0] == rd_ptr_q[PTR_W-1:0]);
	assign in_ready  = !full;
	assign out_valid = !empty;
	assign out_op    = buf_q[rd_ptr_q[PTR_W-1:0]];

	// Pointer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_valid && out_ready) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wr_ptr_q[PTR_W-1:0]] <= in_op;
		end
	end

endmodule

// ===== hw/rtl/tccs_back.sv =====
// ----------------------------------------------------------------------------
// tccs_back: screen store and operation engine
// Holds the screen store, carries out queued operations (cell write, event
// emit, cell read, scroll copy, clear fill), runs the blanking pass after
// reset and drives the result register.
module tccs_back #(
	parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    text_color,
	input  logic          q_valid,
	output logic          q_ready,
	input  tccs_pkg::op_t q_op,
	output logic          init_done,
	output logic          out_valid,
	input  logic          out_ready,
	output tccs_pkg::ev_t out_ev
);

	localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY   = ADDR_W'(CELLS - SCREEN_WIDTH - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCREEN_WIDTH);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD_WAIT,
		ST_SC_RD,
		ST_SC_WR,
		ST_FILL
	} state_t;

	state_t          state_q;
	logic [ADDR_W-1:0] cnt_q;
	tccs_pkg::op_t   cur_q;
	logic            out_valid_q;
	tccs_pkg::ev_t   out_q;
	logic [15:0]     mem_q [CELLS];
	logic [15:0]     rd_q;

	logic              pop;
	logic              slot_free;
	logic              ev_load;
	logic [ADDR_W-1:0] head_addr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;

	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && q_valid && slot_free;
	assign q_ready   = pop;
	assign init_done = (state_q != ST_INIT);
	assign out_valid = out_valid_q;
	assign out_ev    = out_q;
	assign head_addr = ADDR_W'(q_op.row) * ROW_STRIDE + ADDR_W'(q_op.col);

	// The result register takes a new event when an operation finishes.
	assign ev_load = (pop && ((q_op.op == tccs_pkg::OP_WRITE) ||
	                          (q_op.op == tccs_pkg::OP_EMIT))) ||
	                 (state_q == ST_RD_WAIT) ||
	                 ((state_q == ST_FILL) && (cnt_q == LAST_CELL));

	// Store port control for each state.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {text_color, tccs_pkg::CHAR_BLANK};
		re    = 1'b0;
		raddr = head_addr;
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = {tccs_pkg::RESET_COLOR, tccs_pkg::CHAR_BLANK};
			end
			ST_IDLE: begin
				if (pop && (q_op.op == tccs_pkg::OP_WRITE)) begin
					we    = 1'b1;
					waddr = head_addr;
					wdata = {text_color, q_op.ch};
				end
				if (pop && (q_op.op == tccs_pkg::OP_READ)) begin
					re = 1'b1;
				end
			end
			ST_SC_RD: begin
				re    = 1'b1;
				raddr = cnt_q + ROW_STRIDE;
			end
			ST_SC_WR: begin
				we    = 1'b1;
				wdata = rd_q;
			end
			ST_FILL: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Screen store with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						cur_q <= q_op;
						case (q_op.op)
							tccs_pkg::OP_WRITE: begin
								out_q <= {q_op.ev, q_op.col, q_op.row,
								          text_color, q_op.ch, q_op.last};
							end
							tccs_pkg::OP_EMIT: begin
								out_q <= {q_op.ev, q_op.col, q_op.row, 16'h0000, q_op.last};
							end
							tccs_pkg::OP_READ: begin
								state_q <= ST_RD_WAIT;
							end
							tccs_pkg::OP_SCROLL: begin
								cnt_q   <= '0;
								state_q <= ST_SC_RD;
							end
							tccs_pkg::OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					out_q   <= {cur_q.ev, cur_q.col, cur_q.row, rd_q, cur_q.last};
					state_q <= ST_IDLE;
				end
				ST_SC_RD: begin
					state_q <= ST_SC_WR;
				end
				ST_SC_WR: begin
					// After the last copied cell the bottom row is filled with blanks.
					cnt_q   <= cnt_q + 1'b1;
					state_q <= (cnt_q == LAST_COPY) ? ST_FILL : ST_SC_RD;
				end
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
						out_q   <= {cur_q.ev, cur_q.col, cur_q.row, 16'h0000, cur_q.last};
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: text-mode console engine
// Cursor, character cell store, line wrap and scroll behind stream channels.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ channel (mode in s_tuser, character and target
// column and row in s_tdata). Events leave on the m_ channel with the event
// kind in m_tuser and m_tlast high on the final event of a command. The
// cfg_ channel writes the color byte and is always ready.
// The front end takes a new command only once every operation of the last
// one is queued. A plain character raises m_tvalid with its event after the
// front-end pending buffer, the queue and the result register; the front end
// queues one operation per cycle while the queue has room. Clear sweeps the
// store at one cell a cycle. Scroll copies each cell up one row with a read
// state and then a write state, and then blanks the bottom row.
// After reset a blanking pass over every cell runs with s_tready low, and
// configuration writes are still taken.
// When m_tready is low the result register holds its event, while up to
// QUEUE_DEPTH queued operations and one further command are still accepted.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
	parameter int SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tccs_pkg::SCREEN_HEIGHT_DEF,
	parameter int QUEUE_DEPTH   = tccs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], target_col[15:8], target_row[23:16]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // event_col[6:0], event_row[11:7], cell_value[27:12], zero
	output logic [2:0]  m_tuser,   // event_kind[2:0]
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // text_color[7:0]
);

	logic [7:0]    text_color_q;
	logic          init_done;
	logic          fq_valid;
	logic          fq_ready;
	tccs_pkg::op_t fq_op;
	logic          qb_valid;
	logic          qb_ready;
	tccs_pkg::op_t qb_op;
	tccs_pkg::ev_t ev;

	// Color register; a transaction on the configuration channel replaces it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tccs_pkg::RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	tccs_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.mode       (s_tuser),
		.char_code  (s_tdata[7:0]),
		.target_col (s_tdata[15:8]),
		.target_row (s_tdata[23:16]),
		.init_done  (init_done),
		.q_valid    (fq_valid),
		.q_ready    (fq_ready),
		.q_op       (fq_op)
	);

	tccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_op     (fq_op),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_op    (qb_op)
	);

	tccs_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.q_valid    (qb_valid),
		.q_ready    (qb_ready),
		.q_op       (qb_op),
		.init_done  (init_done),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_ev     (ev)
	);

	// Pack the result fields onto the output channel.
	assign m_tdata = {4'h0, ev.cell_value, ev.row, ev.col};
	assign m_tuser = ev.kind;
	assign m_tlast = ev.last;

endmodule
